>>> src/bra_pkg.sv
package bra_pkg;

    localparam int NUM_BLOCKS       = 256;
    localparam int BLOCK_BYTES_LOG2 = 16;
    localparam int ACTIVE_RESET     = 256;

    localparam int OP_W   = 3;
    localparam int ADDR_W = 8;
    localparam int CNT_W  = 9;
    localparam int VAL_W  = 10;
    localparam int REQ_W  = 25;
    localparam int STAT_W = 2;
    localparam int WANT_W = REQ_W - BLOCK_BYTES_LOG2 + 1;
    localparam int CMP_W  = ((WANT_W > CNT_W) ? WANT_W : CNT_W) + 1;
    localparam int WQ_N   = 3;

    localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
    localparam logic [OP_W-1:0] OP_EXTEND = 3'd1;
    localparam logic [OP_W-1:0] OP_RESIZE = 3'd2;
    localparam logic [OP_W-1:0] OP_FREE   = 3'd3;
    localparam logic [OP_W-1:0] OP_SIZE   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_HEAD = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NO_FREE  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] region_index;
        logic [REQ_W-1:0]  requested_bytes;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] result_index;
        logic [CNT_W-1:0]  size_blocks;
    } rsp_t;

    typedef struct packed {
        logic                    en;
        logic [ADDR_W-1:0]       addr;
        logic signed [VAL_W-1:0] data;
    } wr_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SCAN_END,
        S_HEAD_RD,
        S_HEAD_EV,
        S_NEXT_RD,
        S_NEXT_EV,
        S_APPLY,
        S_WRITE,
        S_FREE_CHK,
        S_FREE_EV,
        S_DONE
    } seq_state_t;

endpackage

>>> src/bra_ram.sv
module bra_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/block_run_allocator.sv
// Block run allocator: keeps a run-length table over a pool of equal blocks.
// Requests arrive on the s_ channel (operation, region_index, requested_bytes)
// and each request produces exactly one transaction on the m_ channel with a
// status, a block index and a size in blocks. The cfg channel writes the pool
// size; it is taken only while the sequencer is idle and restarts the pool as
// one free run.
// One request is worked on at a time. A table memory with one write port and
// one registered read port sets the pace: every run head visited takes a read
// state and an evaluate state. An unknown operation or an index past the pool
// is answered without a table read, a size query or a block that is not an
// allocated head after one head read, extend and resize after reading the head
// and any next run and writing up to three entries, free after merging each
// following free run, and allocate-largest after a walk over every run head.
// The result sits in an output register, so a new request is accepted while a
// previous result is still waiting; if the receiver stalls, the sequencer holds
// its finished result until the output register frees up.
// Reset is synchronous and active low. It sets the pool to 256 blocks and
// clears the per-entry valid bits, so the table reads as one free run at once;
// no clearing pass is needed.
module block_run_allocator (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  bra_pkg::req_t             s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output bra_pkg::rsp_t             m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bra_pkg::CNT_W-1:0] cfg_data
);

    import bra_pkg::*;

    localparam int TAB_AW = $clog2(NUM_BLOCKS);

    function automatic logic [CNT_W-1:0] clamp_active(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        begin
            r = v;
            if (v == '0) begin
                r = CNT_W'(1);
            end else if (32'(v) > NUM_BLOCKS) begin
                r = CNT_W'(NUM_BLOCKS);
            end
            return r;
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] neg_len(input logic [CNT_W-1:0] n);
        return -$signed({1'b0, n});
    endfunction

    function automatic logic signed [VAL_W-1:0] pos_len(input logic [CNT_W-1:0] n);
        return $signed({1'b0, n});
    endfunction

    seq_state_t state_reg, state_next;

    logic [CNT_W-1:0]  active_reg;
    logic              valid_reg [NUM_BLOCKS];
    logic              rd_valid_reg;
    logic              rd_zero_reg;

    logic [OP_W-1:0]   op_reg, op_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [WANT_W-1:0] want_reg, want_next;
    logic [VAL_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  best_reg, best_next;
    logic [ADDR_W-1:0] at_reg, at_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [VAL_W-1:0]  next_reg, next_next;
    logic [CNT_W-1:0]  tn_reg, tn_next;
    logic              nfree_reg, nfree_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    wr_t               wq_reg [WQ_N];
    wr_t               wq_next [WQ_N];
    logic [1:0]        wk_reg, wk_next;
    rsp_t              res_reg, res_next;
    logic              m_valid_reg;
    rsp_t              m_data_reg;

    logic                    ram_we;
    logic [TAB_AW-1:0]       ram_waddr;
    logic signed [VAL_W-1:0] ram_wdata;
    logic [TAB_AW-1:0]       ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;

    logic signed [VAL_W-1:0] rd_value;
    logic                    rd_pos;
    logic [VAL_W-1:0]        rd_mag;
    logic [VAL_W-1:0]        scan_step;
    logic [VAL_W:0]          scan_sum;
    logic                    scan_more;
    logic                    scan_gt;
    logic [CNT_W-1:0]        head_len;
    logic [VAL_W-1:0]        head_next;
    logic                    head_next_ok;
    logic [VAL_W-1:0]        free_n;
    logic                    free_n_ok;
    logic                    base_bad;
    logic                    op_bad;
    logic                    out_free;
    logic                    s_fire;
    logic                    cfg_fire;
    logic [REQ_W-1:0]        req_m1;
    logic [WANT_W-1:0]       want_calc;
    logic [CMP_W-1:0]        want_c;
    logic [CMP_W-1:0]        len_c;
    logic [CMP_W-1:0]        tn_c;
    logic [CMP_W-1:0]        grow_diff;
    logic [CNT_W-1:0]        grow_d;
    logic [CNT_W-1:0]        grow_len;
    logic [ADDR_W-1:0]       grow_head;
    logic [CNT_W-1:0]        ext_len;
    logic [CNT_W-1:0]        shrink_w;
    logic [CNT_W-1:0]        shrink_fr;
    logic [ADDR_W-1:0]       shrink_head;

    bra_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_fire   = s_valid && s_ready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign rd_value = rd_valid_reg ? $signed(ram_rdata) :
                      (rd_zero_reg ? pos_len(active_reg) : '0);
    assign rd_pos       = !rd_value[VAL_W-1] && (rd_value != '0);
    assign rd_mag       = rd_value[VAL_W-1] ? (~rd_value + 1'b1) : rd_value;
    assign scan_step    = (rd_mag == '0) ? VAL_W'(1) : rd_mag;
    assign scan_sum     = {1'b0, i_reg} + {1'b0, scan_step};
    assign scan_more    = scan_sum < {2'b00, active_reg};
    assign scan_gt      = rd_value > pos_len(best_reg);
    assign head_len     = rd_mag[CNT_W-1:0];
    assign head_next    = {2'b00, base_reg} + {1'b0, head_len};
    assign head_next_ok = head_next < {1'b0, active_reg};
    assign free_n       = {2'b00, base_reg} + {1'b0, cur_reg};
    assign free_n_ok    = free_n < {1'b0, active_reg};
    assign base_bad     = {1'b0, base_reg} >= active_reg;
    assign op_bad       = op_reg > OP_SIZE;

    assign req_m1    = s_data.requested_bytes - REQ_W'(1);
    assign want_calc = (s_data.requested_bytes == '0) ? WANT_W'(1) :
                       ({1'b0, req_m1[REQ_W-1:BLOCK_BYTES_LOG2]} + WANT_W'(1));

    assign want_c      = CMP_W'(want_reg);
    assign len_c       = CMP_W'(len_reg);
    assign tn_c        = CMP_W'(tn_reg);
    assign grow_diff   = want_c - len_c;
    assign grow_d      = (tn_c < grow_diff) ? tn_reg : grow_diff[CNT_W-1:0];
    assign grow_len    = len_reg + grow_d;
    assign grow_head   = ADDR_W'(next_reg + {1'b0, grow_d});
    assign ext_len     = len_reg + tn_reg;
    assign shrink_w    = want_reg[CNT_W-1:0];
    assign shrink_fr   = len_reg - shrink_w + (nfree_reg ? tn_reg : '0);
    assign shrink_head = ADDR_W'({1'b0, base_reg} + shrink_w);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_START;
                end
            end
            S_START: begin
                if (op_bad) begin
                    state_next = S_DONE;
                end else if (op_reg == OP_ALLOC) begin
                    state_next = S_SCAN_RD;
                end else if (base_bad) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_HEAD_RD;
                end
            end
            S_SCAN_RD:  state_next = S_SCAN_EV;
            S_SCAN_EV:  state_next = scan_more ? S_SCAN_RD : S_SCAN_END;
            S_SCAN_END: state_next = S_DONE;
            S_HEAD_RD:  state_next = S_HEAD_EV;
            S_HEAD_EV: begin
                if (!rd_value[VAL_W-1] || op_reg == OP_SIZE) begin
                    state_next = S_DONE;
                end else if (op_reg == OP_FREE) begin
                    state_next = S_FREE_CHK;
                end else if (head_next_ok) begin
                    state_next = S_NEXT_RD;
                end else begin
                    state_next = S_APPLY;
                end
            end
            S_NEXT_RD:  state_next = S_NEXT_EV;
            S_NEXT_EV:  state_next = S_APPLY;
            S_APPLY:    state_next = S_WRITE;
            S_WRITE: begin
                if (wk_reg == 2'(WQ_N - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_FREE_CHK: state_next = free_n_ok ? S_FREE_EV : S_DONE;
            S_FREE_EV:  state_next = rd_pos ? S_FREE_CHK : S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        op_next    = op_reg;
        base_next  = base_reg;
        want_next  = want_reg;
        i_next     = i_reg;
        best_next  = best_reg;
        at_next    = at_reg;
        len_next   = len_reg;
        next_next  = next_reg;
        tn_next    = tn_reg;
        nfree_next = nfree_reg;
        cur_next   = cur_reg;
        wk_next    = wk_reg;
        res_next   = res_reg;
        for (int k = 0; k < WQ_N; k++) begin
            wq_next[k] = wq_reg[k];
        end
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    op_next   = s_data.operation;
                    base_next = s_data.region_index;
                    want_next = want_calc;
                end
            end
            S_START: begin
                i_next    = '0;
                best_next = '0;
                at_next   = '0;
                if (op_bad) begin
                    res_next = '{STAT_RANGE, '0, '0};
                end else begin
                    res_next = '{STAT_RANGE, base_reg, '0};
                end
            end
            S_SCAN_EV: begin
                if (scan_gt) begin
                    best_next = rd_value[CNT_W-1:0];
                    at_next   = i_reg[ADDR_W-1:0];
                end
                if (scan_more) begin
                    i_next = scan_sum[VAL_W-1:0];
                end
            end
            S_SCAN_END: begin
                if (best_reg == '0) begin
                    res_next = '{STAT_NO_FREE, '0, '0};
                end else begin
                    res_next = '{STAT_OK, at_reg, best_reg};
                end
            end
            S_HEAD_EV: begin
                len_next   = head_len;
                cur_next   = head_len;
                next_next  = head_next;
                nfree_next = 1'b0;
                tn_next    = '0;
                if (!rd_value[VAL_W-1]) begin
                    res_next = '{STAT_NOT_HEAD, base_reg, '0};
                end else begin
                    res_next = '{STAT_OK, base_reg, head_len};
                end
            end
            S_NEXT_EV: begin
                nfree_next = rd_pos;
                tn_next    = rd_value[CNT_W-1:0];
            end
            S_APPLY: begin
                wk_next  = '0;
                res_next = '{STAT_OK, base_reg, len_reg};
                for (int k = 0; k < WQ_N; k++) begin
                    wq_next[k] = '{1'b0, '0, '0};
                end
                if (op_reg == OP_EXTEND) begin
                    if (nfree_reg) begin
                        wq_next[0] = '{1'b1, next_reg[ADDR_W-1:0], '0};
                        wq_next[1] = '{1'b1, base_reg, neg_len(ext_len)};
                        res_next.size_blocks = ext_len;
                    end
                end else if (want_c < len_c) begin
                    wq_next[0] = '{nfree_reg, next_reg[ADDR_W-1:0], '0};
                    wq_next[1] = '{1'b1, shrink_head, pos_len(shrink_fr)};
                    wq_next[2] = '{1'b1, base_reg, neg_len(shrink_w)};
                    res_next.size_blocks = shrink_w;
                end else if (want_c > len_c && nfree_reg) begin
                    wq_next[0] = '{1'b1, next_reg[ADDR_W-1:0], '0};
                    wq_next[1] = '{tn_reg > grow_d, grow_head, pos_len(tn_reg - grow_d)};
                    wq_next[2] = '{1'b1, base_reg, neg_len(grow_len)};
                    res_next.size_blocks = grow_len;
                end
            end
            S_WRITE: begin
                wk_next = wk_reg + 2'd1;
            end
            S_FREE_CHK: begin
                next_next = free_n;
                res_next  = '{STAT_OK, base_reg, '0};
            end
            S_FREE_EV: begin
                if (rd_pos) begin
                    cur_next = cur_reg + rd_value[CNT_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == S_IDLE);
        cfg_ready = (state_reg == S_IDLE);
        ram_we    = 1'b0;
        ram_waddr = base_reg;
        ram_wdata = '0;
        ram_raddr = base_reg;
        case (state_reg)
            S_SCAN_RD: begin
                ram_raddr = i_reg[TAB_AW-1:0];
            end
            S_SCAN_END: begin
                ram_we    = (best_reg != '0);
                ram_waddr = at_reg;
                ram_wdata = neg_len(best_reg);
            end
            S_NEXT_RD: begin
                ram_raddr = next_reg[TAB_AW-1:0];
            end
            S_WRITE: begin
                ram_we    = wq_reg[wk_reg].en;
                ram_waddr = wq_reg[wk_reg].addr;
                ram_wdata = wq_reg[wk_reg].data;
            end
            S_FREE_CHK: begin
                ram_raddr = free_n[TAB_AW-1:0];
                ram_we    = !free_n_ok;
                ram_wdata = pos_len(cur_reg);
            end
            S_FREE_EV: begin
                ram_we = 1'b1;
                if (rd_pos) begin
                    ram_waddr = next_reg[TAB_AW-1:0];
                    ram_wdata = '0;
                end else begin
                    ram_wdata = pos_len(cur_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            active_reg <= clamp_active(CNT_W'(ACTIVE_RESET));
            for (int k = 0; k < NUM_BLOCKS; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_fire) begin
                active_reg <= clamp_active(cfg_data);
                for (int k = 0; k < NUM_BLOCKS; k++) begin
                    valid_reg[k] <= 1'b0;
                end
            end else if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_valid_reg <= valid_reg[ram_raddr];
        rd_zero_reg  <= (ram_raddr == '0);
        op_reg       <= op_next;
        base_reg     <= base_next;
        want_reg     <= want_next;
        i_reg        <= i_next;
        best_reg     <= best_next;
        at_reg       <= at_next;
        len_reg      <= len_next;
        next_reg     <= next_next;
        tn_reg       <= tn_next;
        nfree_reg    <= nfree_next;
        cur_reg      <= cur_next;
        wk_reg       <= wk_next;
        res_reg      <= res_next;
        for (int k = 0; k < WQ_N; k++) begin
            wq_reg[k] <= wq_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            m_data_reg <= res_reg;
        end
    end

endmodule

>>> src/bra_checker.sv
module bra_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input bra_pkg::req_t             s_data,
    input logic                      m_valid,
    input logic                      m_ready,
    input bra_pkg::rsp_t             m_data,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [bra_pkg::CNT_W-1:0] cfg_data
);

    import bra_pkg::*;

    // A held result keeps its valid and its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
    else $error("result changed while stalled");

    // Requests are handled one at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !cfg_ready)
    else $error("request accepted while busy");

    // Rejected requests report an empty region.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_RANGE || m_data.status == STAT_NOT_HEAD)
        |-> m_data.size_blocks == '0)
    else $error("rejected request reports a size");

    // A pool with no free run answers with index zero and size zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STAT_NO_FREE
        |-> m_data.result_index == '0 && m_data.size_blocks == '0)
    else $error("no-free result carries data");

    // No region is larger than the largest pool of NUM_BLOCKS blocks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_data.size_blocks) <= NUM_BLOCKS)
    else $error("size exceeds pool");

endmodule

bind block_run_allocator bra_checker u_bra_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import bra_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 600;
    localparam int PHASE_ITEMS  = 172;
    localparam int BLOCK_BYTES  = 1 << BLOCK_BYTES_LOG2;
    localparam int MAX_BYTES    = 16777216;

    typedef struct {
        int runs [0:NUM_BLOCKS];
        int active;
    } pool_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    req_t             s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    rsp_t             m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data  = '0;

    req_t  pending_reqs [$];
    rsp_t  expected_rsps [$];
    pool_t model_pool;
    pool_t plan_pool;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycles         = 0;
    int n_req          = 0;
    int n_rsp          = 0;
    int n_cfg          = 0;
    int n_err          = 0;
    int status_seen [4];
    bit s_taken        = 1'b0;

    block_run_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void pool_init(inout pool_t p, input logic [CNT_W-1:0] blocks);
        int i;
        if (blocks == 0) begin
            p.active = 1;
        end else if (blocks > NUM_BLOCKS) begin
            p.active = NUM_BLOCKS;
        end else begin
            p.active = blocks;
        end
        for (i = 0; i <= NUM_BLOCKS; i++) p.runs[i] = 0;
        p.runs[0] = p.active;
    endfunction

    function automatic bit run_free(input pool_t p, input int i);
        return i >= 0 && i < p.active && p.runs[i] > 0;
    endfunction

    function automatic rsp_t make_rsp(input logic [STAT_W-1:0] st, input int idx, input int sz);
        rsp_t r;
        r.status       = st;
        r.result_index = idx[ADDR_W-1:0];
        r.size_blocks  = sz[CNT_W-1:0];
        return r;
    endfunction

    function automatic rsp_t pool_apply(inout pool_t p, input req_t r);
        int base, len, nxt, want, diff, head, fr, avail, n;
        int best, at, i, h, step;
        logic [REQ_W-1:0] req;
        base = r.region_index;
        req  = r.requested_bytes;
        if (r.operation > OP_SIZE) begin
            return make_rsp(STAT_RANGE, 0, 0);
        end
        if (r.operation == OP_ALLOC) begin
            best = 0;
            at   = -1;
            i    = 0;
            while (i < p.active) begin
                h    = p.runs[i];
                step = (h > 0) ? h : -h;
                if (h > best) begin
                    best = h;
                    at   = i;
                end
                if (step == 0) step = 1;
                i += step;
            end
            if (at < 0) return make_rsp(STAT_NO_FREE, 0, 0);
            len        = p.runs[at];
            p.runs[at] = -len;
            return make_rsp(STAT_OK, at, len);
        end
        if (base >= p.active) return make_rsp(STAT_RANGE, base, 0);
        if (p.runs[base] >= 0) return make_rsp(STAT_NOT_HEAD, base, 0);
        len = -p.runs[base];
        nxt = base + len;
        case (r.operation)
            OP_EXTEND: begin
                if (run_free(p, nxt)) begin
                    len += p.runs[nxt];
                    p.runs[nxt]  = 0;
                    p.runs[base] = -len;
                end
            end
            OP_RESIZE: begin
                if (req == 0) begin
                    want = 1;
                end else begin
                    want = ((req - 1) >> BLOCK_BYTES_LOG2) + 1;
                end
                diff = want - len;
                if (diff < 0) begin
                    head = nxt + diff;
                    fr   = -diff;
                    if (run_free(p, nxt)) begin
                        fr += p.runs[nxt];
                        p.runs[nxt] = 0;
                    end
                    p.runs[head] = fr;
                    len          = want;
                    p.runs[base] = -len;
                end else if (diff > 0 && run_free(p, nxt)) begin
                    avail = p.runs[nxt];
                    if (avail < diff) diff = avail;
                    p.runs[nxt] = 0;
                    if (avail > diff && nxt + diff <= NUM_BLOCKS) begin
                        p.runs[nxt + diff] = avail - diff;
                    end
                    len += diff;
                    p.runs[base] = -len;
                end
            end
            OP_FREE: begin
                p.runs[base] = len;
                while (run_free(p, base + p.runs[base])) begin
                    n = base + p.runs[base];
                    p.runs[base] += p.runs[n];
                    p.runs[n] = 0;
                end
                return make_rsp(STAT_OK, base, 0);
            end
            default: begin
            end
        endcase
        return make_rsp(STAT_OK, base, len);
    endfunction

    function automatic int pick_head(input pool_t p);
        int heads [$];
        int i, h;
        i = 0;
        while (i < p.active) begin
            h = p.runs[i];
            if (h < 0) heads.push_back(i);
            i += (h == 0) ? 1 : ((h > 0) ? h : -h);
        end
        if (heads.size() == 0) return -1;
        return heads[$urandom_range(heads.size() - 1)];
    endfunction

    function void queue_req(input logic [OP_W-1:0] op, input int idx, input int bytes);
        req_t r;
        r.operation       = op;
        r.region_index    = idx[ADDR_W-1:0];
        r.requested_bytes = bytes[REQ_W-1:0];
        void'(pool_apply(plan_pool, r));
        pending_reqs.push_back(r);
    endfunction

    function void queue_random_req();
        int roll, op, idx, bytes, k, len;
        idx  = pick_head(plan_pool);
        roll = $urandom_range(99);
        if (roll < 22) begin
            op = OP_ALLOC;
        end else if (roll < 34) begin
            op = OP_EXTEND;
        end else if (roll < 60) begin
            op = OP_RESIZE;
        end else if (roll < 78) begin
            op = OP_FREE;
        end else if (roll < 90) begin
            op = OP_SIZE;
        end else if (roll < 95) begin
            op = $urandom_range(2 ** OP_W - 1, OP_SIZE + 1);
        end else begin
            op  = $urandom_range(OP_SIZE, OP_EXTEND);
            idx = -1;
        end
        if (op == OP_ALLOC || idx < 0 || $urandom_range(99) < 12) begin
            idx = $urandom_range(ADDR_W ** 2 * 4 - 1);
        end
        roll = $urandom_range(99);
        if (roll < 40) begin
            k     = $urandom_range(8, 1);
            bytes = k * BLOCK_BYTES + $urandom_range(2) - 1;
        end else if (roll < 60) begin
            len = (plan_pool.runs[idx] < 0) ? -plan_pool.runs[idx] : 1;
            k   = $urandom_range(4);
            k   = len + k - 2;
            if (k < 0) k = 0;
            bytes = k * BLOCK_BYTES;
            if (bytes > MAX_BYTES) bytes = MAX_BYTES;
        end else if (roll < 85) begin
            bytes = $urandom_range(MAX_BYTES);
        end else begin
            case ($urandom_range(3))
                0: bytes = 0;
                1: bytes = 1;
                2: bytes = MAX_BYTES - 1;
                default: bytes = MAX_BYTES;
            endcase
        end
        queue_req(OP_W'(op), idx, bytes);
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_pool_size(input logic [CNT_W-1:0] blocks);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= blocks;
        do @(posedge aclk); while (!cfg_ready);
        pool_init(model_pool, blocks);
        pool_init(plan_pool, blocks);
        n_cfg++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            s_taken = 1'b0;
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_reqs.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        rsp_t exp_rsp;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("** block_run_allocator: FAILED **");
            $finish;
        end else if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_rsps.push_back(pool_apply(model_pool, s_data));
                s_taken = 1'b1;
                n_req++;
            end
            if (m_valid && m_ready) begin
                n_rsp++;
                status_seen[m_data.status]++;
                if (expected_rsps.size() == 0) begin
                    n_err++;
                    if (n_err <= 40) begin
                        $display("%0t: unexpected transaction: status %0d index %0d size %0d",
                                 $time, m_data.status, m_data.result_index, m_data.size_blocks);
                    end
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (m_data.status != exp_rsp.status
                            || m_data.result_index != exp_rsp.result_index
                            || m_data.size_blocks != exp_rsp.size_blocks) begin
                        n_err++;
                        if (n_err <= 40) begin
                            $display("%0t: mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     $time, exp_rsp.status, exp_rsp.result_index,
                                     exp_rsp.size_blocks, m_data.status,
                                     m_data.result_index, m_data.size_blocks);
                        end
                    end
                end
            end
        end
    end

    initial begin
        logic [CNT_W-1:0] pool_sizes [8];
        int phase;
        pool_sizes = '{9'd0, 9'd2, 9'd511, 9'd256, 9'd1, 9'd17, 9'd0, 9'd255};
        pool_sizes[6] = CNT_W'($urandom_range(300, 3));
        pool_init(model_pool, CNT_W'(ACTIVE_RESET));
        pool_init(plan_pool, CNT_W'(ACTIVE_RESET));
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Full pool after reset: whole-pool allocation, shrink, partial and full grow,
        // extend, free with merging, and the rejected cases.
        queue_req(OP_SIZE, 0, 0);
        queue_req(OP_ALLOC, 255, MAX_BYTES);
        queue_req(OP_ALLOC, 0, 0);
        queue_req(OP_SIZE, 0, MAX_BYTES - 1);
        queue_req(OP_RESIZE, 0, 0);
        queue_req(OP_RESIZE, 0, 2 * BLOCK_BYTES + 1);
        queue_req(OP_RESIZE, 0, MAX_BYTES);
        queue_req(OP_RESIZE, 0, 4 * BLOCK_BYTES);
        queue_req(OP_EXTEND, 0, 0);
        queue_req(OP_RESIZE, 0, 255 * BLOCK_BYTES);
        queue_req(OP_SIZE, 255, 0);
        queue_req(OP_FREE, 0, 0);
        queue_req(OP_FREE, 0, 0);
        queue_req(OP_W'(OP_SIZE + 1), 255, MAX_BYTES - 1);
        queue_req(OP_W'(OP_SIZE + 2), 255, MAX_BYTES - 1);
        queue_req(OP_W'(OP_SIZE + 3), 255, MAX_BYTES - 1);
        wait_idle();

        // Small pool: indexes past the pool, tied largest runs, and the pool end.
        write_pool_size(9'd5);
        queue_req(OP_SIZE, 5, 0);
        queue_req(OP_FREE, 255, 0);
        queue_req(OP_ALLOC, 0, 0);
        queue_req(OP_RESIZE, 0, 2 * BLOCK_BYTES);
        queue_req(OP_ALLOC, 0, 0);
        queue_req(OP_RESIZE, 2, BLOCK_BYTES);
        queue_req(OP_FREE, 0, 0);
        queue_req(OP_ALLOC, 0, 0);
        queue_req(OP_ALLOC, 0, 0);
        queue_req(OP_EXTEND, 3, 0);
        queue_req(OP_RESIZE, 3, 3 * BLOCK_BYTES);
        wait_idle();

        for (phase = 0; phase < 8; phase++) begin
            write_pool_size(pool_sizes[phase]);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            repeat (PHASE_ITEMS) queue_random_req();
            wait_idle();
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d requests over %0d pool sizes with sender gaps and stalls.",
                 n_req, n_cfg + 1);
        $display("Responses: %0d ok, %0d out of range, %0d not a head, %0d no free; %0d errors.",
                 status_seen[STAT_OK], status_seen[STAT_RANGE], status_seen[STAT_NOT_HEAD],
                 status_seen[STAT_NO_FREE], n_err + expected_rsps.size());
        if (n_err == 0 && expected_rsps.size() == 0) begin
            $display("** block_run_allocator: PASSED **");
        end else begin
            $display("** block_run_allocator: FAILED **");
        end
        $finish;
    end

endmodule
